// ===== rtl/gd2_pkg.sv =====
// Shared types and constants for the 3x3 binomial reduce-by-two block.
// No dependencies; imported by every module of the block.
package gd2_pkg;

    // Fixed field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 4;

    // Default store dimensions
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 4'd0,
        REG_FRAME_HEIGHT = 4'd1
    } gd2_reg_idx_t;

    // Position tag of one source pixel, carried from the counters to the filter
    typedef struct packed {
        logic             odd_row;    // source row is odd
        logic             row_one;    // source row is 1
        logic             row_zero;   // source row is 0
        logic             last_row;   // last row of the frame
        logic             odd_col;    // source column is odd
        logic             col_one;    // source column is 1
        logic             col_zero;   // source column is 0
        logic             last_col;   // last column of the row
        logic [PIX_W-1:0] pixel;
    } gd2_tag_t;

endpackage

// ===== rtl/gd2_line_store.sv =====
// Two line stores (latest even and latest odd source row), read-first.
// Depends on gd2_pkg for the pixel width.
module gd2_line_store #(
    parameter int MAX_WIDTH = gd2_pkg::DEF_MAX_WIDTH,
    parameter int XW        = $clog2(MAX_WIDTH)
) (
    input  logic                      aclk,
    input  logic                      access,    // read both, write one
    input  logic                      wr_odd,    // 1: write odd store, 0: even store
    input  logic [XW-1:0]             addr,
    input  logic [gd2_pkg::PIX_W-1:0] wdata,
    output logic [gd2_pkg::PIX_W-1:0] rd_even,
    output logic [gd2_pkg::PIX_W-1:0] rd_odd
);
    import gd2_pkg::*;

    logic [PIX_W-1:0] even_mem [MAX_WIDTH];
    logic [PIX_W-1:0] odd_mem  [MAX_WIDTH];

    // Even store: old data is read out on the edge that writes the new pixel
    always_ff @(posedge aclk) begin
        if (access) begin
            rd_even <= even_mem[addr];
            if (!wr_odd) begin
                even_mem[addr] <= wdata;
            end
        end
    end

    // Odd store
    always_ff @(posedge aclk) begin
        if (access) begin
            rd_odd <= odd_mem[addr];
            if (wr_odd) begin
                odd_mem[addr] <= wdata;
            end
        end
    end

endmodule

// ===== rtl/gd2_filter.sv =====
// Vertical and horizontal 1-2-1 filter stage with the output register.
// Depends on gd2_pkg for the tag struct and pixel width.
module gd2_filter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,       // a source word enters the stage
    input  gd2_pkg::gd2_tag_t         tag_in,
    input  logic [gd2_pkg::PIX_W-1:0] rd_even,    // aligned with the stage register
    input  logic [gd2_pkg::PIX_W-1:0] rd_odd,
    output logic                      in_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [gd2_pkg::PIX_W-1:0] m_pixel_out,
    output logic                      m_row_end,
    output logic                      m_frame_end
);
    import gd2_pkg::*;

    logic             stg_valid_reg, stg_valid_next;
    gd2_tag_t         tag_reg;
    logic [PIX_W-1:0] vs_one_reg, vs_one_next;
    logic [PIX_W-1:0] vs_two_reg, vs_two_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_row_end_reg, out_frame_end_reg;

    logic             advance, fire;
    logic             have_v, emit;
    logic [PIX_W-1:0] top, left, vert, res;
    logic [PIX_W+1:0] vsum, hsum;

    // Handshake: stage moves when the output slot is free or being taken
    always_comb begin
        advance  = !out_valid_reg || m_ready;
        in_ready = !stg_valid_reg || advance;
        fire     = stg_valid_reg && advance;
    end

    // Vertical result
    always_comb begin
        have_v = 1'b0;
        top    = tag_reg.row_one ? rd_even : rd_odd;
        vsum   = '0;
        if (tag_reg.odd_row) begin
            vsum   = {2'b00, top} + {1'b0, rd_even, 1'b0} + {2'b00, tag_reg.pixel};
            have_v = 1'b1;
        end else if (tag_reg.last_row) begin
            // bottom edge: the row below repeats this one
            top    = tag_reg.row_zero ? tag_reg.pixel : rd_odd;
            vsum   = {2'b00, top} + {1'b0, tag_reg.pixel, 1'b0} + {2'b00, tag_reg.pixel};
            have_v = 1'b1;
        end
        vert = vsum[PIX_W+1:2];
    end

    // Horizontal result
    always_comb begin
        emit = 1'b0;
        left = tag_reg.col_one ? vs_one_reg : vs_two_reg;
        hsum = '0;
        if (tag_reg.odd_col) begin
            hsum = {2'b00, left} + {1'b0, vs_one_reg, 1'b0} + {2'b00, vert};
            emit = have_v;
        end else if (tag_reg.last_col) begin
            // right edge: the column to the right repeats this one
            left = tag_reg.col_zero ? vert : vs_one_reg;
            hsum = {2'b00, left} + {1'b0, vert, 1'b0} + {2'b00, vert};
            emit = have_v;
        end
        res = hsum[PIX_W+1:2];
    end

    // Next-state logic
    always_comb begin
        stg_valid_next = in_ready ? load : stg_valid_reg;
        out_valid_next = advance ? (fire && emit) : out_valid_reg;
        vs_one_next    = vs_one_reg;
        vs_two_next    = vs_two_reg;
        if (fire && have_v) begin
            vs_two_next = vs_one_reg;
            vs_one_next = vert;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            vs_one_reg    <= '0;
            vs_two_reg    <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            vs_one_reg    <= vs_one_next;
            vs_two_reg    <= vs_two_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load && in_ready) begin
            tag_reg <= tag_in;
        end
        if (fire && emit) begin
            out_pix_reg       <= res;
            out_row_end_reg   <= tag_reg.last_col;
            out_frame_end_reg <= tag_reg.last_col && tag_reg.last_row;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pix_reg;
    assign m_row_end   = out_row_end_reg;
    assign m_frame_end = out_frame_end_reg;

endmodule

// ===== rtl/gauss_3x3_decimate_by_two_top.sv =====
// Top level of the 3x3 binomial reduce-by-two block: registers, position
// counters and line store access. Depends on gd2_pkg, gd2_line_store, gd2_filter.
//
// Usage:
//   Source pixels of a frame enter in raster order on the s_ channel, one word
//   per accepted handshake. For each even row and even column a filtered pixel
//   leaves on the m_ channel, with row_end on the last pixel of an output row
//   and frame_end on the last pixel of the frame. Output is ceil(w/2) by
//   ceil(h/2); edges replicate the nearest row or column.
//   Throughput is one source pixel per cycle while s_ready is high: each
//   pixel does one read and one write of the two line stores (one port each)
//   at the edge it is accepted, which also loads the filter stage register;
//   the filter result then enters the output register and shows on m_valid
//   once the output slot is free.
//   Frame size is written on the cfg_ channel while the block is idle;
//   cfg_ready is always high. Reset clears the positions and the pipeline; the
//   line stores need no clearing since every entry is written before it is read.
//   When the receiver stalls, the output holds and the filter stage keeps one
//   more word; s_ready drops only when both are full.
module gauss_3x3_decimate_by_two_top #(
    parameter int MAX_WIDTH  = gd2_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gd2_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gd2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gd2_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gd2_pkg::PIX_W-1:0]     s_pixel_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gd2_pkg::PIX_W-1:0]     m_pixel_out,
    output logic                          m_row_end,
    output logic                          m_frame_end
);
    import gd2_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int XS = (CFG_W > XW + 1) ? CFG_W : XW + 1;
    localparam int YS = (CFG_W > YW + 1) ? CFG_W : YW + 1;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [XW-1:0]    col_reg, col_next;
    logic [YW-1:0]    row_reg, row_next;

    logic [XS-1:0]    w_eff;
    logic [YS-1:0]    h_eff;
    logic             last_col, last_row, accept, in_ready;
    gd2_tag_t         tag;
    logic [PIX_W-1:0] rd_even, rd_odd;

    // Configuration writes
    assign cfg_ready = 1'b1;
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Effective size: zero acts as one, oversize acts as the store limit
    always_comb begin
        w_eff = XS'(width_reg);
        if (width_reg == '0) begin
            w_eff = XS'(1);
        end else if (XS'(width_reg) > XS'(MAX_WIDTH)) begin
            w_eff = XS'(MAX_WIDTH);
        end
        h_eff = YS'(height_reg);
        if (height_reg == '0) begin
            h_eff = YS'(1);
        end else if (YS'(height_reg) > YS'(MAX_HEIGHT)) begin
            h_eff = YS'(MAX_HEIGHT);
        end
        last_col = XS'(col_reg) >= (w_eff - XS'(1));
        last_row = YS'(row_reg) >= (h_eff - YS'(1));
    end

    // Position tag of the arriving pixel
    always_comb begin
        tag.odd_row  = row_reg[0];
        tag.row_one  = row_reg == YW'(1);
        tag.row_zero = row_reg == '0;
        tag.last_row = last_row;
        tag.odd_col  = col_reg[0];
        tag.col_one  = col_reg == XW'(1);
        tag.col_zero = col_reg == '0;
        tag.last_col = last_col;
        tag.pixel    = s_pixel_in;
    end

    // Raster position counters
    assign s_ready = in_ready;
    assign accept  = s_valid && in_ready;
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + YW'(1);
            end else begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    gd2_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .XW        (XW)
    ) u_store (
        .aclk    (aclk),
        .access  (accept),
        .wr_odd  (row_reg[0]),
        .addr    (col_reg),
        .wdata   (s_pixel_in),
        .rd_even (rd_even),
        .rd_odd  (rd_odd)
    );

    gd2_filter u_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .tag_in      (tag),
        .rd_even     (rd_even),
        .rd_odd      (rd_odd),
        .in_ready    (in_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule

// ===== tb/sv/gauss_3x3_decimate_by_two_top_test.sv =====
// Self-checking testbench for gauss_3x3_decimate_by_two_top. It streams raster pixels,
// writes frame sizes and predicts every reduced pixel, then checks each output word.
// Depends on gd2_pkg and the RTL of the block.
module gauss_3x3_decimate_by_two_top_test;
    import gd2_pkg::*;

    localparam int MAX_W           = DEF_MAX_WIDTH;
    localparam int MAX_H           = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_PIXELS    = 160;
    localparam int N_PLAN          = 33;

    // Index outside the register map, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 4'hF;
    localparam logic [CFG_W-1:0]     SIZE_ALL_ONES = 12'hFFF;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } out_word_t;

    typedef enum logic {
        STEP_PIXEL,
        STEP_REG
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;   // pixel value in the low bits for pixel steps
        logic                 typed;  // use the typed-in word instead of the prediction
        out_word_t            want;
    } plan_row_t;

    // DUT ports, all inputs known from time zero
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_in  = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [PIX_W-1:0]     m_pixel_out;
    logic                 m_row_end;
    logic                 m_frame_end;

    gauss_3x3_decimate_by_two_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: registers, line stores, positions, vertical history
    out_word_t        reduced_q[$];
    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    logic [PIX_W-1:0] even_line [MAX_W];
    logic [PIX_W-1:0] odd_line  [MAX_W];
    logic [10:0]      col_pos    = '0;
    logic [10:0]      row_pos    = '0;
    int               vert_back1 = 0;
    int               vert_back2 = 0;

    int fail_count    = 0;
    int cycle_count   = 0;
    int phase_pixels  = 0;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // Directed steps: odd sizes mid-frame, single pixel frames, flat 2x2 frames,
    // an ignored register index, and a 3x3 checkerboard
    plan_row_t plan [N_PLAN] = '{
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd128, 1'b0, '0},
        '{STEP_REG,   REG_FRAME_WIDTH,  12'd0, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd7,   1'b0, '0},
        '{STEP_REG,   REG_FRAME_HEIGHT, 12'd2, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd64,  1'b0, '0},
        '{STEP_REG,   REG_FRAME_WIDTH,  12'd1, 1'b0, '0},
        '{STEP_REG,   REG_FRAME_HEIGHT, 12'd1, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b1, '{8'd0,   1'b1, 1'b1}},
        '{STEP_PIXEL, '0, 12'd255, 1'b1, '{8'd255, 1'b1, 1'b1}},
        '{STEP_REG,   REG_FRAME_WIDTH,  12'd2, 1'b0, '0},
        '{STEP_REG,   REG_FRAME_HEIGHT, 12'd2, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b1, '{8'd255, 1'b1, 1'b1}},
        '{STEP_REG,   REG_UNUSED, SIZE_ALL_ONES, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b1, '{8'd0,   1'b1, 1'b1}},
        '{STEP_REG,   REG_FRAME_WIDTH,  12'd3, 1'b0, '0},
        '{STEP_REG,   REG_FRAME_HEIGHT, 12'd3, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0},
        '{STEP_PIXEL, '0, 12'd0,   1'b0, '0},
        '{STEP_PIXEL, '0, 12'd255, 1'b0, '0}
    };

    // Register value to frame size: zero acts as one, oversize as the store size
    function automatic int eff_size(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    function automatic bit at_frame_start();
        return (col_pos == '0) && (row_pos == '0);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_W-1:0] rand_size(input int top_size);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return 12'd1;
        return CFG_W'($urandom_range(1, top_size));
    endfunction

    // One source pixel through the predictor: vertical 1-2-1 on odd or last rows,
    // horizontal 1-2-1 on odd or last columns
    task automatic reduce_pixel(input logic [PIX_W-1:0] p, output bit emit,
                                output out_word_t o);
        int w, h, x, r, pv, ev, od, top, left, v, res;
        bit last_col, last_row, have_v;
        w        = eff_size(width_reg, MAX_W);
        h        = eff_size(height_reg, MAX_H);
        x        = int'(col_pos);
        r        = int'(row_pos);
        pv       = int'(p);
        last_col = (x >= w - 1);
        last_row = (r >= h - 1);
        ev       = int'(even_line[x]);
        od       = int'(odd_line[x]);
        have_v   = 1'b0;
        emit     = 1'b0;
        v        = 0;
        res      = 0;
        o        = '0;

        if (r % 2 == 1) begin
            top = (r == 1) ? ev : od;
            v = (top + 2 * ev + pv) >> 2;
            odd_line[x] = p;
            have_v = 1'b1;
        end else begin
            even_line[x] = p;
            // bottom edge replicates this row
            if (last_row) begin
                top = (r == 0) ? pv : od;
                v = (top + 3 * pv) >> 2;
                have_v = 1'b1;
            end
        end

        if (have_v) begin
            if (x % 2 == 1) begin
                left = (x == 1) ? vert_back1 : vert_back2;
                res = (left + 2 * vert_back1 + v) >> 2;
                emit = 1'b1;
            end else if (last_col) begin
                left = (x == 0) ? v : vert_back1;
                res = (left + 3 * v) >> 2;
                emit = 1'b1;
            end
            vert_back2 = vert_back1;
            vert_back1 = v;
        end
        if (emit) o = '{res[PIX_W-1:0], last_col, last_col && last_row};

        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? 11'd0 : 11'(r + 1);
        end else begin
            col_pos = 11'(x + 1);
        end
    endtask

    // Offer one pixel word; valid stays high across back-to-back words
    task automatic push_pixel(input logic [PIX_W-1:0] p, input bit typed,
                              input out_word_t want);
        bit emit;
        out_word_t o;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        reduce_pixel(p, emit, o);
        if (typed) reduced_q.push_back(want);
        else if (emit) reduced_q.push_back(o);
        phase_pixels++;
    endtask

    // Drop valid, wait for every expected word and the pipeline to drain
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reduced_q.size() != 0 || hold_served != hold_requests || hold_left != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_FRAME_WIDTH) width_reg = data;
        else if (idx == REG_FRAME_HEIGHT) height_reg = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frame();
        do push_pixel(rand_pixel(), 1'b0, '0);
        while (!at_frame_start());
    endtask

    // Start a frame, then cut it short by a size write and finish it
    task automatic cut_frame(input int n, input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        repeat (n) push_pixel(rand_pixel(), 1'b0, '0);
        write_reg(idx, data);
        while (!at_frame_start()) push_pixel(rand_pixel(), 1'b0, '0);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Output check against the oldest predicted word
    always @(posedge aclk) begin : check_out
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reduced_q.size() == 0) begin
                $error("pixel_out: no word expected, got %0d", m_pixel_out);
                fail_count++;
            end else begin
                want = reduced_q.pop_front();
                if (m_pixel_out !== want.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel, m_pixel_out);
                    fail_count++;
                end
                if (m_row_end !== want.row_end) begin
                    $error("row_end: expected %0d, got %0d", want.row_end, m_row_end);
                    fail_count++;
                end
                if (m_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, m_frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gauss_3x3_decimate_by_two_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, starting at the reset size, with size writes mid-frame
        for (int i = 0; i < N_PLAN; i++) begin
            if (plan[i].kind == STEP_REG) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                push_pixel(plan[i].data[PIX_W-1:0], plan[i].typed, plan[i].want);
            end
        end

        // Random frames, one idling mode per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                    // receiver holds off while a whole frame is offered
                    write_reg(REG_FRAME_WIDTH, 12'd16);
                    write_reg(REG_FRAME_HEIGHT, 12'd8);
                    hold_requests++;
                    run_frame();
                    // oversize width, one row, cut short by a width of one
                    write_reg(REG_FRAME_WIDTH, SIZE_ALL_ONES);
                    write_reg(REG_FRAME_HEIGHT, 12'd1);
                    cut_frame(120, REG_FRAME_WIDTH, 12'd1);
                end
                1: begin
                    tx_gap_pct   = 59;
                    rx_stall_pct = 0;
                    // oversize height, one column, cut short by a height of one
                    write_reg(REG_FRAME_WIDTH, 12'd1);
                    write_reg(REG_FRAME_HEIGHT, SIZE_ALL_ONES);
                    cut_frame(60, REG_FRAME_HEIGHT, 12'd1);
                end
                2: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 59;
                    write_reg(REG_FRAME_WIDTH, 12'd2048);
                    write_reg(REG_FRAME_HEIGHT, 12'd2);
                    cut_frame(60, REG_FRAME_WIDTH, 12'd1);
                end
                default: begin
                    tx_gap_pct   = 37;
                    rx_stall_pct = 37;
                end
            endcase

            phase_pixels = 0;
            while (phase_pixels < PHASE_PIXELS) begin
                write_reg(REG_FRAME_WIDTH, rand_size(16));
                write_reg(REG_FRAME_HEIGHT, rand_size(6));
                if ($urandom_range(0, 4) != 0) begin
                    run_frame();
                end else begin
                    // size change in the middle of a frame; width only shrinks
                    n = $urandom_range(1, eff_size(width_reg, MAX_W) *
                                          eff_size(height_reg, MAX_H));
                    repeat (n) push_pixel(rand_pixel(), 1'b0, '0);
                    if ($urandom_range(0, 1) == 0) begin
                        write_reg(REG_FRAME_HEIGHT, rand_size(8));
                    end else begin
                        write_reg(REG_FRAME_WIDTH,
                                  CFG_W'($urandom_range(0, eff_size(width_reg, MAX_W))));
                    end
                    while (!at_frame_start()) push_pixel(rand_pixel(), 1'b0, '0);
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("gauss_3x3_decimate_by_two_top_test: PASS");
        end else begin
            $display("gauss_3x3_decimate_by_two_top_test: FAIL");
        end
        $finish;
    end

endmodule
